// ----- src/command_and_position_frame_parser_macros.svh -----
// Assertion macros for the command and position frame parser.
`ifndef COMMAND_AND_POSITION_FRAME_PARSER_MACROS_SVH
`define COMMAND_AND_POSITION_FRAME_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Check a property outside reset.
`define CPFP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cpfp assertion failed");
// Check a property in every cycle, reset included.
`define CPFP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("cpfp assertion failed");
`else
`define CPFP_ASSERT(label, prop)
`define CPFP_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- src/cpfp_pkg.sv -----
// Shared types, byte codes and decode function of the frame parser.
package cpfp_pkg;

   localparam logic [7:0] SYNC_CHAR    = 8'h36;
   localparam logic [7:0] COMPACT_CHAR = 8'h37;
   localparam logic [7:0] MEASURE_CHAR = 8'h38;
   localparam logic [7:0] FRAME_CHAR   = 8'h35;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   localparam int FRAME_LEN = 7;
   localparam int SLOT_W    = 3;
   localparam int POS_W     = 11;
   localparam int NIB_W     = 4;

   typedef enum logic [1:0] {
      PH_WAIT    = 2'd0,
      PH_CMD     = 2'd1,
      PH_CAPTURE = 2'd2,
      PH_TAIL    = 2'd3
   } phase_type;

   typedef logic [NIB_W-1:0] nibble_type;

   typedef struct packed {
      logic             compact_cmd;
      logic             measure_cmd;
      logic             notify_pulse;
      logic             frame_done;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      nibble_type       item_kind;
   } result_type;

   // Decode three decimal digits, hundreds first.
   function automatic logic [POS_W-1:0] decode3(input nibble_type d2, input nibble_type d1,
                                                input nibble_type d0);
      logic [POS_W-1:0] hund;
      logic [POS_W-1:0] tens;
      hund = POS_W'(d2) * POS_W'(100);
      tens = POS_W'(d1) * POS_W'(10);
      return hund + tens + POS_W'(d0);
   endfunction

endpackage

// ----- src/cpfp_fsm.sv -----
// Parse state machine, frame store and position decode.
module cpfp_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           rx_byte,
   output cpfp_pkg::result_type result
);

   cpfp_pkg::phase_type                    phase_ff, phase_in;
   logic [cpfp_pkg::SLOT_W-1:0]            slot_ff, slot_in;
   cpfp_pkg::nibble_type                   nib_ff [cpfp_pkg::FRAME_LEN];
   cpfp_pkg::nibble_type                   nib_in [cpfp_pkg::FRAME_LEN];

   // Hold state between words, advance on each word taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cpfp_pkg::PH_WAIT;
         slot_ff  <= '0;
         for (int i = 0; i < cpfp_pkg::FRAME_LEN; i++) begin
            nib_ff[i] <= '0;
         end
      end else if (fire) begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         for (int i = 0; i < cpfp_pkg::FRAME_LEN; i++) begin
            nib_ff[i] <= nib_in[i];
         end
      end
   end

   // Next state, pulses and store update for the current word.
   always_comb begin
      phase_in              = phase_ff;
      slot_in               = slot_ff;
      result.compact_cmd    = 1'b0;
      result.measure_cmd    = 1'b0;
      result.notify_pulse   = 1'b0;
      result.frame_done     = 1'b0;
      for (int i = 0; i < cpfp_pkg::FRAME_LEN; i++) begin
         nib_in[i] = nib_ff[i];
      end
      case (phase_ff)
         cpfp_pkg::PH_WAIT: begin
            if (rx_byte == cpfp_pkg::SYNC_CHAR) begin
               phase_in            = cpfp_pkg::PH_CMD;
               result.notify_pulse = 1'b1;
            end
         end
         cpfp_pkg::PH_CMD: begin
            if (rx_byte == cpfp_pkg::COMPACT_CHAR) begin
               result.compact_cmd = 1'b1;
            end else if (rx_byte == cpfp_pkg::MEASURE_CHAR) begin
               result.measure_cmd = 1'b1;
            end else if (rx_byte == cpfp_pkg::FRAME_CHAR) begin
               phase_in = cpfp_pkg::PH_CAPTURE;
            end else begin
               result.notify_pulse = 1'b1;
            end
         end
         cpfp_pkg::PH_CAPTURE: begin
            if (slot_ff < cpfp_pkg::SLOT_W'(cpfp_pkg::FRAME_LEN)) begin
               for (int i = 0; i < cpfp_pkg::FRAME_LEN; i++) begin
                  if (slot_ff == cpfp_pkg::SLOT_W'(i)) begin
                     nib_in[i] = rx_byte[cpfp_pkg::NIB_W-1:0];
                  end
               end
               slot_in = slot_ff + 1'b1;
               if (slot_in >= cpfp_pkg::SLOT_W'(cpfp_pkg::FRAME_LEN)) begin
                  phase_in = cpfp_pkg::PH_TAIL;
               end
            end else begin
               phase_in = cpfp_pkg::PH_TAIL;
            end
         end
         cpfp_pkg::PH_TAIL: begin
            if (rx_byte == cpfp_pkg::NEWLINE_CHAR) begin
               phase_in            = cpfp_pkg::PH_CMD;
               slot_in             = '0;
               result.notify_pulse = 1'b1;
               result.frame_done   = 1'b1;
            end
         end
         default: begin
            phase_in = cpfp_pkg::PH_WAIT;
         end
      endcase
      // Decode from the store as it stands after this word.
      result.pos_x     = cpfp_pkg::decode3(nib_in[0], nib_in[1], nib_in[2]);
      result.pos_y     = cpfp_pkg::decode3(nib_in[3], nib_in[4], nib_in[5]);
      result.item_kind = nib_in[6];
   end

endmodule

// ----- src/command_and_position_frame_parser.sv -----
// Top level of the command and position frame parser.
//
// One received byte per word in, one result word out for every byte. The
// block sustains one word per clock while the output is not stalled: a
// byte lands in the input register, is parsed from there against the phase
// and frame store, and the result (command pulses plus the x/y position and
// kind decoded from the seven-nibble store) is loaded into the output
// register. The input register keeps taking a byte while a result waits
// on a stalled output; the input stalls only when both registers are full.
// The phase, slot and store reset to wait-for-sync, slot zero and all zero.
`include "command_and_position_frame_parser_macros.svh"

module command_and_position_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_compact_cmd,
   output logic        rsp_measure_cmd,
   output logic        rsp_notify_pulse,
   output logic        rsp_frame_done,
   output logic [10:0] rsp_pos_x,
   output logic [10:0] rsp_pos_y,
   output logic [3:0]  rsp_item_kind
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   cpfp_pkg::result_type rsp_ff;
   cpfp_pkg::result_type parse_result;
   logic                 advance;
   logic                 req_take;
   logic [2:0]           rsp_pulses;

   // Move a word from input to output register when the output is free.
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold the valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= parse_result;
      end
   end

   cpfp_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .rx_byte (in_byte_ff),
      .result  (parse_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_compact_cmd  = rsp_ff.compact_cmd;
   assign rsp_measure_cmd  = rsp_ff.measure_cmd;
   assign rsp_notify_pulse = rsp_ff.notify_pulse;
   assign rsp_frame_done   = rsp_ff.frame_done;
   assign rsp_pos_x        = rsp_ff.pos_x;
   assign rsp_pos_y        = rsp_ff.pos_y;
   assign rsp_item_kind    = rsp_ff.item_kind;

   // Gather the command pulses for the at-most-one-hot check.
   assign rsp_pulses = {rsp_ff.compact_cmd, rsp_ff.measure_cmd, rsp_ff.notify_pulse};

   `CPFP_ASSERT(a_done_notifies, rsp_valid_ff && rsp_ff.frame_done |-> rsp_ff.notify_pulse)
   `CPFP_ASSERT(a_pulse_onehot, rsp_valid_ff |-> $onehot0(rsp_pulses))
   `CPFP_ASSERT(a_advance_fills, advance |=> rsp_valid_ff)
   `CPFP_ASSERT(a_stall_needs_full, req_stall |-> in_valid_ff && rsp_valid_ff)
   `CPFP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff && !in_valid_ff)

endmodule
